### hdl/ptt_pkg.sv
// Shared types and constants for the peer token table.
// Used by the slot cell, the top level and the checker; depends on nothing.
`default_nettype none
package ptt_pkg;

  localparam int SLOT_COUNT = 8;
  localparam int IDX_W = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
  localparam int MAC_W = 48;
  localparam int TIME_W = 32;
  localparam int CNT_W = 4;
  localparam int CMD_W = 2;

  localparam logic [TIME_W-1:0] TIMEOUT_RESET = 32'd3000;
  localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};
  localparam logic [MAC_W-1:0] MAC_ZERO = {MAC_W{1'b0}};
  localparam logic [MAC_W-1:0] MAC_ONES = {MAC_W{1'b1}};

  localparam logic [CMD_W-1:0] CMD_ACQUIRE = 2'd0;
  localparam logic [CMD_W-1:0] CMD_RELEASE = 2'd1;
  localparam logic [CMD_W-1:0] CMD_SWEEP = 2'd2;
  localparam logic [CMD_W-1:0] CMD_CLEAR = 2'd3;

  typedef logic [IDX_W-1:0] idx_t;

  typedef struct packed {
    logic active;
    logic [CMD_W-1:0] cmd;
    logic [MAC_W-1:0] mac;
    logic [TIME_W-1:0] now;
    logic has_match;
    idx_t match_idx;
    logic [TIME_W-1:0] held;
    logic has_free;
    idx_t free_idx;
    logic has_aged;
    idx_t aged_idx;
    logic [CNT_W-1:0] count;
  } tok_t;

  typedef struct packed {
    logic clear_all;
    logic set_en;
    idx_t set_idx;
    logic rel_en;
    idx_t rel_idx;
    logic [MAC_W-1:0] mac;
    logic [TIME_W-1:0] stamp;
  } upd_t;

endpackage
`default_nettype wire

### hdl/ptt_cell.sv
// One slot of the peer token table and one stage of the scan chain.
// Depends on ptt_pkg for the token and update types.
`default_nettype none
module ptt_cell (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire ptt_pkg::idx_t              slot_idx,
  input  wire logic [ptt_pkg::TIME_W-1:0] timeout,
  input  wire ptt_pkg::tok_t              tok_in,
  input  wire ptt_pkg::upd_t              upd,
  output ptt_pkg::tok_t                   tok_out
);

  logic valid;
  logic [ptt_pkg::MAC_W-1:0] peer;
  logic [ptt_pkg::TIME_W-1:0] stamp;

  logic [ptt_pkg::TIME_W-1:0] age;
  logic aged;
  logic hit;
  ptt_pkg::tok_t tok_next;

  assign age = tok_in.now - stamp;
  assign aged = valid && (age >= timeout);
  assign hit = valid && (peer == tok_in.mac);

  always_comb begin
    tok_next = tok_in;
    if (hit && !tok_in.has_match) begin
      tok_next.has_match = 1'b1;
      tok_next.match_idx = slot_idx;
      tok_next.held = age;
    end
    if (!valid && !tok_in.has_free) begin
      tok_next.has_free = 1'b1;
      tok_next.free_idx = slot_idx;
    end
    if (aged && !tok_in.has_aged) begin
      tok_next.has_aged = 1'b1;
      tok_next.aged_idx = slot_idx;
    end
    if (tok_in.cmd == ptt_pkg::CMD_SWEEP && aged && tok_in.count != ptt_pkg::CNT_MAX) begin
      tok_next.count = tok_in.count + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tok_out.active <= 1'b0;
    end else begin
      tok_out.active <= tok_in.active;
    end
    tok_out.cmd <= tok_next.cmd;
    tok_out.mac <= tok_next.mac;
    tok_out.now <= tok_next.now;
    tok_out.has_match <= tok_next.has_match;
    tok_out.match_idx <= tok_next.match_idx;
    tok_out.held <= tok_next.held;
    tok_out.has_free <= tok_next.has_free;
    tok_out.free_idx <= tok_next.free_idx;
    tok_out.has_aged <= tok_next.has_aged;
    tok_out.aged_idx <= tok_next.aged_idx;
    tok_out.count <= tok_next.count;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else begin
      priority if (upd.clear_all) begin
        valid <= 1'b0;
      end else if (upd.set_en && upd.set_idx == slot_idx) begin
        valid <= 1'b1;
      end else if (upd.rel_en && upd.rel_idx == slot_idx) begin
        valid <= 1'b0;
      end else if (tok_in.active && tok_in.cmd == ptt_pkg::CMD_SWEEP && aged) begin
        valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (upd.set_en && upd.set_idx == slot_idx) begin
      peer <= upd.mac;
      stamp <= upd.stamp;
    end
  end

endmodule
`default_nettype wire

### hdl/peer_token_table_with_aging.sv
// Top level of the peer token table: request channel, result register and
// the chain of slot cells. Depends on ptt_pkg and ptt_cell.
//
// A request is scanned by a token that walks the row of SLOT_COUNT slot cells,
// one cell per cycle, gathering the matching slot, the first free slot and the
// first aged slot; sweep clears aged slots as the token passes. The token is
// then held in the fin register, and the decision is applied and the result
// register loaded, before the next request is accepted. The result register
// frees the request side while a result waits; a request completes only once
// the previous result has been taken. The timeout register is written through
// the cfg channel, which is always ready, and must only be written while idle.
`default_nettype none
module peer_token_table_with_aging (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  // Fields from bit 0: peer_addr[47:0], now_time[31:0].
  input  wire logic [79:0] s_axis_tdata,
  // Fields from bit 0: command[1:0].
  input  wire logic [1:0]  s_axis_tuser,
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  // Fields from bit 0: granted, matched, held_time[31:0], reclaimed_stale,
  // sweep_count[3:0], one zero pad bit.
  output logic [39:0]      m_axis_tdata,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [31:0] cfg_data
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_SCAN = 2'd1;
  localparam logic [1:0] ST_DONE = 2'd2;

  logic [1:0] state;
  logic [1:0] state_next;
  logic [ptt_pkg::TIME_W-1:0] timeout;
  ptt_pkg::tok_t inj;
  ptt_pkg::tok_t fin;
  ptt_pkg::tok_t chain [ptt_pkg::SLOT_COUNT];
  ptt_pkg::upd_t upd;
  logic accept;
  logic finish;
  logic mac_ok;

  logic granted;
  logic matched;
  logic [ptt_pkg::TIME_W-1:0] held;
  logic reclaimed;
  logic [ptt_pkg::CNT_W-1:0] count;

  assign s_axis_tready = (state == ST_IDLE);
  assign accept = s_axis_tvalid && s_axis_tready;
  assign cfg_ready = 1'b1;
  assign finish = (state == ST_DONE) && (!m_axis_tvalid || m_axis_tready);

  always_comb begin
    inj = '0;
    inj.active = accept;
    inj.cmd = s_axis_tuser;
    inj.mac = s_axis_tdata[47:0];
    inj.now = s_axis_tdata[79:48];
  end

  genvar g;
  generate
    for (g = 0; g < ptt_pkg::SLOT_COUNT; g++) begin : g_cell
      ptt_cell u_cell (
        .clk     (clk),
        .rst     (rst),
        .slot_idx(ptt_pkg::idx_t'(g)),
        .timeout (timeout),
        .tok_in  ((g == 0) ? inj : chain[(g == 0) ? 0 : g - 1]),
        .upd     (upd),
        .tok_out (chain[g])
      );
    end
  endgenerate

  always_comb begin
    upd = '0;
    upd.mac = fin.mac;
    upd.stamp = fin.now;
    granted = 1'b0;
    matched = 1'b0;
    held = '0;
    reclaimed = 1'b0;
    count = '0;
    mac_ok = (fin.mac != ptt_pkg::MAC_ZERO) && (fin.mac != ptt_pkg::MAC_ONES);
    unique case (fin.cmd)
      ptt_pkg::CMD_ACQUIRE: begin
        if (mac_ok) begin
          priority if (fin.has_match) begin
            matched = 1'b1;
            held = fin.held;
          end else if (fin.has_free) begin
            upd.set_en = finish;
            upd.set_idx = fin.free_idx;
            granted = 1'b1;
          end else if (fin.has_aged) begin
            upd.set_en = finish;
            upd.set_idx = fin.aged_idx;
            granted = 1'b1;
            reclaimed = 1'b1;
          end
        end
      end
      ptt_pkg::CMD_RELEASE: begin
        if (mac_ok && fin.has_match) begin
          upd.rel_en = finish;
          upd.rel_idx = fin.match_idx;
          matched = 1'b1;
          held = fin.held;
        end
      end
      ptt_pkg::CMD_SWEEP: begin
        count = fin.count;
      end
      ptt_pkg::CMD_CLEAR: begin
        upd.clear_all = finish;
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: if (accept) state_next = ST_SCAN;
      ST_SCAN: if (chain[ptt_pkg::SLOT_COUNT-1].active) state_next = ST_DONE;
      ST_DONE: if (finish) state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      timeout <= ptt_pkg::TIMEOUT_RESET;
      m_axis_tvalid <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg_valid && cfg_ready) begin
        timeout <= cfg_data;
      end
      if (finish) begin
        m_axis_tvalid <= 1'b1;
      end else if (m_axis_tready) begin
        m_axis_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_SCAN && chain[ptt_pkg::SLOT_COUNT-1].active) begin
      fin <= chain[ptt_pkg::SLOT_COUNT-1];
    end
    if (finish) begin
      m_axis_tdata <= {1'b0, count, reclaimed, held, matched, granted};
    end
  end

endmodule
`default_nettype wire

### hdl/ptt_checker.sv
// Port-level checks for the peer token table, bound to the top level.
// Depends on ptt_pkg and peer_token_table_with_aging.
`default_nettype none
module ptt_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        s_axis_tvalid,
  input wire logic        s_axis_tready,
  input wire logic        m_axis_tvalid,
  input wire logic        m_axis_tready,
  input wire logic [39:0] m_axis_tdata
);

  logic [3:0] cnt;
  assign cnt = m_axis_tdata[38:35];

  a_result_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("Stalled result changed or dropped.");

  a_one_request: assert property (@(posedge clk) disable iff (rst)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("Request accepted while a scan was running.");

  a_reclaim_grant: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tdata[34] |-> m_axis_tdata[0] && !m_axis_tdata[1])
    else $error("Reclaim reported without a grant.");

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && cnt != 4'd0 |->
      cnt <= 4'(ptt_pkg::SLOT_COUNT) && m_axis_tdata[34:0] == 35'd0)
    else $error("Sweep count out of range or mixed with other fields.");

endmodule

bind peer_token_table_with_aging ptt_checker u_ptt_checker (.*);
`default_nettype wire
